@@ src/xrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrd_pkg
// Shared widths, limits, register codes and the per-item operation that the
// control stage hands to the store datapath.
// ----------------------------------------------------------------------------
package xrd_pkg;

    localparam int DATA_W      = 8;
    localparam int POS_W       = 16;
    localparam int ROW_LEN_W   = 13;
    localparam int MAX_ROW     = 4096;
    localparam int MAX_RECORD  = 64;
    localparam int SIZE_BYTES  = 2;

    localparam int ROW_ADDR_W  = $clog2(MAX_ROW);
    localparam int SLOT_W      = $clog2(MAX_RECORD);
    localparam int REC_ADDR_W  = 2 * SLOT_W;
    localparam int ADDR_W      = (ROW_ADDR_W > REC_ADDR_W) ? ROW_ADDR_W : REC_ADDR_W;
    localparam int ROW_DEPTH   = MAX_ROW;
    localparam int REC_DEPTH   = MAX_RECORD * MAX_RECORD;

    // register index codes (paddr bit 2)
    localparam logic REG_DECODE  = 1'b0;
    localparam logic REG_ROW_LEN = 1'b1;

    // one item on its way from the control stage to the store stage
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic              incomplete;
        logic              bad;
        logic              use_xor;
        logic              wr_en;
        logic              sel_rec;
        logic [ADDR_W-1:0] addr;
        logic              decode;
    } t_op;

endpackage

@@ src/xrd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrd_ctrl
// Position, record size and seen-size tracking; turns each accepted byte into
// a store address and a set of flags for the store stage.
// ----------------------------------------------------------------------------
module xrd_ctrl
    import xrd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [DATA_W-1:0]    i_data,
    input  logic                 i_last,
    input  logic                 i_decode,
    input  logic [ROW_LEN_W-1:0] i_row_length,
    output t_op                  o_op
);

    logic [POS_W-1:0]      r_pos, n_pos;
    logic [POS_W-1:0]      r_size, n_size;
    logic                  r_frd, n_frd;
    logic                  r_delta, n_delta;
    logic [MAX_RECORD-1:0] r_seen, n_seen;

    logic [ROW_LEN_W-1:0]  rlen;
    logic [ROW_LEN_W-1:0]  pos_row;
    logic [ROW_LEN_W-1:0]  pos_inc;
    logic [POS_W-1:0]      size_hdr;
    logic [POS_W-1:0]      hdr_m1;
    logic [POS_W-1:0]      cur_m1;
    logic                  hdr_bad;
    logic                  cur_bad;
    logic [POS_W-1:0]      rec_len;
    logic [POS_W:0]        pos_p1;
    logic [POS_W-1:0]      pos_next;

    // clamp of the row length
    assign rlen     = (i_row_length > ROW_LEN_W'(MAX_ROW)) ? ROW_LEN_W'(MAX_ROW)
                                                            : i_row_length;
    assign pos_row  = (r_pos >= POS_W'(rlen)) ? '0 : r_pos[ROW_LEN_W-1:0];
    assign pos_inc  = pos_row + 1'b1;

    // record size decode
    assign size_hdr = {r_size[POS_W-1:DATA_W], i_data};
    assign hdr_m1   = size_hdr - 1'b1;
    assign cur_m1   = r_size - 1'b1;
    assign hdr_bad  = (size_hdr < POS_W'(SIZE_BYTES)) || (size_hdr > POS_W'(MAX_RECORD));
    assign cur_bad  = (r_size < POS_W'(SIZE_BYTES)) || (r_size > POS_W'(MAX_RECORD));
    assign rec_len  = (cur_bad && (r_size < POS_W'(SIZE_BYTES))) ? POS_W'(SIZE_BYTES)
                                                                   : r_size;
    assign pos_p1   = {1'b0, r_pos} + 1'b1;

    // per-byte decision and next state
    always_comb begin
        n_size   = r_size;
        n_frd    = r_frd;
        n_delta  = r_delta;
        n_seen   = r_seen;
        pos_next = r_pos;

        o_op            = '0;
        o_op.data       = i_data;
        o_op.last       = i_last;
        o_op.decode     = i_decode;

        if (rlen != '0) begin
            // row mode
            o_op.use_xor = r_frd;
            o_op.wr_en   = 1'b1;
            o_op.addr    = ADDR_W'(pos_row[ROW_ADDR_W-1:0]);
            if (pos_inc >= rlen) begin
                pos_next = '0;
                n_frd    = 1'b1;
            end else begin
                pos_next = POS_W'(pos_inc);
            end
        end else if (r_pos == '0) begin
            // first size byte
            n_size   = {i_data, {DATA_W{1'b0}}};
            n_delta  = 1'b0;
            pos_next = POS_W'(1);
        end else if (r_pos == POS_W'(1)) begin
            // second size byte
            n_size = size_hdr;
            if (hdr_bad) begin
                o_op.bad = 1'b1;
                n_delta  = 1'b0;
                pos_next = (size_hdr < POS_W'(SIZE_BYTES)) ? '0 : POS_W'(2);
            end else begin
                n_delta = r_seen[hdr_m1[SLOT_W-1:0]];
                n_seen[hdr_m1[SLOT_W-1:0]] = 1'b1;
                pos_next = (size_hdr <= POS_W'(SIZE_BYTES)) ? '0 : POS_W'(2);
            end
        end else begin
            // record body
            o_op.bad = cur_bad;
            if (!cur_bad && (r_pos < POS_W'(MAX_RECORD))) begin
                o_op.use_xor = r_delta;
                o_op.wr_en   = 1'b1;
                o_op.sel_rec = 1'b1;
                o_op.addr    = ADDR_W'({cur_m1[SLOT_W-1:0], r_pos[SLOT_W-1:0]});
            end
            pos_next = (pos_p1 >= {1'b0, rec_len}) ? '0 : pos_p1[POS_W-1:0];
        end

        o_op.incomplete = i_last && (pos_next != '0);
        n_pos           = pos_next;

        // buffer end clears the tracking state
        if (i_last) begin
            n_pos   = '0;
            n_size  = '0;
            n_frd   = 1'b0;
            n_delta = 1'b0;
            n_seen  = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_size  <= '0;
            r_frd   <= 1'b0;
            r_delta <= 1'b0;
            r_seen  <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_size  <= n_size;
            r_frd   <= n_frd;
            r_delta <= n_delta;
            r_seen  <= n_seen;
        end
    end

endmodule

@@ src/xrd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrd_datapath
// Row and record stores: read on accept, xor and write back as the item
// leaves the store stage, with forwarding for back-to-back hits on the same
// entry, then an output register toward the downstream side.
// ----------------------------------------------------------------------------
module xrd_datapath
    import xrd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_op               i_op,
    input  logic              i_m_ready,
    output logic              o_s_ready,
    output logic              o_m_valid,
    output logic [DATA_W-1:0] o_m_byte,
    output logic              o_m_incomplete,
    output logic              o_m_bad,
    output logic              o_m_last
);

    logic [DATA_W-1:0] r_row_mem [ROW_DEPTH];
    logic [DATA_W-1:0] r_rec_mem [REC_DEPTH];
    logic [DATA_W-1:0] r_row_q;
    logic [DATA_W-1:0] r_rec_q;

    logic              r_s1_v;
    t_op               r_s1;
    logic              r_fwd;
    logic [DATA_W-1:0] r_fwd_data;

    logic              r_out_v;
    logic [DATA_W-1:0] r_out_byte;
    logic              r_out_inc;
    logic              r_out_bad;
    logic              r_out_last;

    logic              s1_adv;
    logic [DATA_W-1:0] ref_byte;
    logic [DATA_W-1:0] res_byte;
    logic [DATA_W-1:0] orig_byte;
    logic              fwd_hit;

    assign s1_adv    = r_s1_v && (!r_out_v || i_m_ready);
    assign o_s_ready = !r_s1_v || !r_out_v || i_m_ready;

    // reference byte, forwarded when the previous item wrote the same entry
    assign ref_byte  = r_fwd ? r_fwd_data : (r_s1.sel_rec ? r_rec_q : r_row_q);
    assign res_byte  = r_s1.use_xor ? (r_s1.data ^ ref_byte) : r_s1.data;
    assign orig_byte = (r_s1.use_xor && r_s1.decode) ? res_byte : r_s1.data;
    assign fwd_hit   = s1_adv && r_s1.wr_en && (r_s1.sel_rec == i_op.sel_rec)
                       && (r_s1.addr == i_op.addr);

    // row store
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.wr_en && !r_s1.sel_rec) begin
            r_row_mem[r_s1.addr[ROW_ADDR_W-1:0]] <= orig_byte;
        end
        if (i_accept) begin
            r_row_q <= r_row_mem[i_op.addr[ROW_ADDR_W-1:0]];
        end
    end

    // record store
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.wr_en && r_s1.sel_rec) begin
            r_rec_mem[r_s1.addr[REC_ADDR_W-1:0]] <= orig_byte;
        end
        if (i_accept) begin
            r_rec_q <= r_rec_mem[i_op.addr[REC_ADDR_W-1:0]];
        end
    end

    // store stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1       <= i_op;
            r_fwd      <= fwd_hit;
            r_fwd_data <= orig_byte;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_byte <= res_byte;
            r_out_inc  <= r_s1.incomplete;
            r_out_bad  <= r_s1.bad;
            r_out_last <= r_s1.last;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (i_m_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_m_valid      = r_out_v;
    assign o_m_byte       = r_out_byte;
    assign o_m_incomplete = r_out_inc;
    assign o_m_bad        = r_out_bad;
    assign o_m_last       = r_out_last;

endmodule

@@ src/xor_row_delta_codec_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_row_delta_codec_core
// Byte stream codec that xors each byte with its counterpart one row earlier
// or in the previous record of the same size.
// ----------------------------------------------------------------------------
// One byte is taken every cycle unless a stalled output side holds tready
// low, and each byte gives exactly one result byte, offered on the output
// through the store stage register and the output register. The stores keep
// that rate: each byte reads its reference entry on acceptance and writes
// the original byte back as it leaves the store stage, and a byte that
// needs the entry its predecessor is writing gets it by forwarding.
// tlast closes a buffer; all position, size and seen-size tracking clears
// after it. The stores hold no reset value and need no clearing pass.
// The user writes configuration (decode_mode at 0x0, row_length at 0x4) via
// the register port only while no byte is in flight; the block does not check.
// ----------------------------------------------------------------------------
module xor_row_delta_codec_core
    import xrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [0] incomplete, [1] bad_size
    output logic        m_axis_tlast,   // last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 r_decode;
    logic [ROW_LEN_W-1:0] r_row_length;
    logic                 cfg_wr;
    logic                 accept;
    t_op                  op;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign accept = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode     <= 1'b0;
            r_row_length <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_DECODE:  r_decode     <= pwdata[0];
                REG_ROW_LEN: r_row_length <= pwdata[ROW_LEN_W-1:0];
                default:     r_decode     <= r_decode;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_DECODE:  prdata = {31'b0, r_decode};
            REG_ROW_LEN: prdata = {{(32-ROW_LEN_W){1'b0}}, r_row_length};
            default:     prdata = '0;
        endcase
    end

    xrd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_decode     (r_decode),
        .i_row_length (r_row_length),
        .o_op         (op)
    );

    xrd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_op           (op),
        .i_m_ready      (m_axis_tready),
        .o_s_ready      (s_axis_tready),
        .o_m_valid      (m_axis_tvalid),
        .o_m_byte       (m_axis_tdata),
        .o_m_incomplete (m_axis_tuser[0]),
        .o_m_bad        (m_axis_tuser[1]),
        .o_m_last       (m_axis_tlast)
    );

endmodule

@@ src/xrd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrd_checker
// Port-level checks of the codec core, bound to the top level.
// ----------------------------------------------------------------------------
module xrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // incomplete is only flagged on the last byte of a buffer
    a_inc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("incomplete flag off the last byte");

    // an empty output register never blocks the input side
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output empty");

    // no result item right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item valid after reset");

endmodule

bind xor_row_delta_codec_core xrd_checker u_xrd_checker (.*);

@@ sim/tb_xor_row_delta_codec_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_row_delta_codec_core
// Streams byte buffers through the codec in row and record mode, encoding and
// decoding, and checks every output byte against a model of the xor transform.
// The sender works in bursts with random gaps and the receiver stalls on a
// rotating pattern. A short hand-written set covers record size corner cases
// and a partial row, then random buffers run under several register settings.
// ----------------------------------------------------------------------------
import xrd_pkg::*;

// one byte as the input stream carries it
typedef struct packed {
    logic [7:0] data;
    logic       last;
} t_stream_byte;

// one byte as the output stream carries it
typedef struct packed {
    logic [7:0] out_byte;
    logic       incomplete;
    logic       bad_size;
    logic       last;
} t_codec_byte;

class codec_scoreboard;

    logic [7:0]   row_mem [MAX_ROW];
    logic [7:0]   rec_mem [REC_DEPTH];
    bit           seen [MAX_RECORD];
    int unsigned  byte_pos;
    logic [15:0]  rec_size;
    bit           row_done;
    bit           use_delta;
    bit           decode;
    int unsigned  row_len;
    t_codec_byte  expected_bytes[$];
    int unsigned  errors;

    function new();
        foreach (row_mem[i]) row_mem[i] = '0;
        foreach (rec_mem[i]) rec_mem[i] = '0;
        decode  = 1'b0;
        row_len = 0;
        errors  = 0;
        clear_buffer();
    endfunction

    function void clear_buffer();
        foreach (seen[i]) seen[i] = 1'b0;
        byte_pos  = 0;
        rec_size  = '0;
        row_done  = 1'b0;
        use_delta = 1'b0;
    endfunction

    function void set_config(bit dec, int unsigned rl);
        decode  = dec;
        row_len = rl & 32'h1FFF;
    endfunction

    function bit size_out_of_range(int unsigned s);
        return (s < SIZE_BYTES) || (s > MAX_RECORD);
    endfunction

    function int unsigned pending();
        return expected_bytes.size();
    endfunction

    // work out the output byte for one accepted input byte
    function void note_byte_in(logic [7:0] d, logic eob);
        t_codec_byte  r;
        logic [7:0]   o;
        logic [7:0]   orig;
        bit           bad;
        int unsigned  p;
        int unsigned  rlen;
        int unsigned  len;
        int unsigned  idx;
        o    = d;
        orig = d;
        bad  = 1'b0;
        rlen = (row_len > MAX_ROW) ? MAX_ROW : row_len;
        if (rlen > 0) begin
            // row mode: xor with the original byte one row up
            p = (byte_pos >= rlen) ? 0 : byte_pos;
            if (row_done) begin
                o    = d ^ row_mem[p];
                orig = decode ? o : d;
            end
            row_mem[p] = orig;
            p++;
            if (p >= rlen) begin
                p        = 0;
                row_done = 1'b1;
            end
            byte_pos = p;
        end else if (byte_pos == 0) begin
            // high size byte
            rec_size  = {d, 8'h00};
            use_delta = 1'b0;
            byte_pos  = 1;
        end else if (byte_pos == 1) begin
            // low size byte, decides delta use and record end
            rec_size = {rec_size[15:8], d};
            if (size_out_of_range(rec_size)) begin
                bad       = 1'b1;
                use_delta = 1'b0;
                byte_pos  = (rec_size < SIZE_BYTES) ? 0 : 2;
            end else begin
                use_delta          = seen[rec_size - 1];
                seen[rec_size - 1] = 1'b1;
                byte_pos           = (rec_size <= SIZE_BYTES) ? 0 : 2;
            end
        end else begin
            // record body
            bad = size_out_of_range(rec_size);
            len = (bad && rec_size < SIZE_BYTES) ? SIZE_BYTES : rec_size;
            if (!bad && byte_pos < MAX_RECORD) begin
                idx = (rec_size - 1) * MAX_RECORD + byte_pos;
                if (use_delta) begin
                    o    = d ^ rec_mem[idx];
                    orig = decode ? o : d;
                end
                rec_mem[idx] = orig;
            end
            p        = byte_pos + 1;
            byte_pos = (p >= len) ? 0 : (p & 32'hFFFF);
        end
        r.out_byte   = o;
        r.incomplete = eob && (byte_pos != 0);
        r.bad_size   = bad;
        r.last       = eob;
        expected_bytes.push_back(r);
        if (eob) clear_buffer();
    endfunction

    // compare one output byte with the oldest expectation
    function void check_byte_out(t_codec_byte got);
        t_codec_byte exp_b;
        if (expected_bytes.size() == 0) begin
            if (errors < 40)
                $display("%0t: unexpected byte, expected none, actual %02h/%0b/%0b/%0b",
                         $time, got.out_byte, got.incomplete, got.bad_size, got.last);
            errors++;
            return;
        end
        exp_b = expected_bytes.pop_front();
        if (got !== exp_b) begin
            if (errors < 40)
                $display("%0t: mismatch expected %02h/%0b/%0b/%0b actual %02h/%0b/%0b/%0b",
                         $time, exp_b.out_byte, exp_b.incomplete, exp_b.bad_size,
                         exp_b.last, got.out_byte, got.incomplete, got.bad_size,
                         got.last);
            errors++;
        end
    endfunction

endclass

module tb_xor_row_delta_codec_core;

    localparam logic [2:0] ADDR_DECODE  = {REG_DECODE, 2'b00};
    localparam logic [2:0] ADDR_ROW_LEN = {REG_ROW_LEN, 2'b00};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;  // end_of_buffer
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_byte
    logic [1:0]  m_axis_tuser;          // [0] incomplete, [1] bad_size
    logic        m_axis_tlast;          // last
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    codec_scoreboard sb = new();
    t_stream_byte    buffer_bytes[$];

    logic [31:0]     ready_pat = '1;
    int unsigned     pat_age   = 0;

    xor_row_delta_codec_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // output side: check accepted items, stall on a rotating pattern
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_byte_out('{out_byte: m_axis_tdata, incomplete: m_axis_tuser[0],
                                bad_size: m_axis_tuser[1], last: m_axis_tlast});
        if (pat_age == 0) begin
            case ($urandom_range(3))
                0:       ready_pat <= '1;
                1:       ready_pat <= $urandom;
                2:       ready_pat <= $urandom | $urandom;
                default: ready_pat <= $urandom & $urandom;
            endcase
            pat_age <= $urandom_range(100, 20);
        end else begin
            ready_pat <= {ready_pat[0], ready_pat[31:1]};
            pat_age   <= pat_age - 1;
        end
        m_axis_tready <= ready_pat[0];
    end

    // safety net against a hung stream
    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void push_byte(logic [7:0] d);
        buffer_bytes.push_back('{data: d, last: 1'b0});
    endfunction

    function automatic void end_buffer();
        buffer_bytes[buffer_bytes.size() - 1].last = 1'b1;
    endfunction

    // size bytes then random body, cut after keep bytes
    function automatic void emit_record(logic [15:0] sz, int unsigned keep);
        for (int k = 0; k < keep; k++) begin
            if (k == 0)      push_byte(sz[15:8]);
            else if (k == 1) push_byte(sz[7:0]);
            else             push_byte(8'($urandom));
        end
    endfunction

    // record-mode buffer: mostly repeated sizes so the delta path gets used
    function automatic void gen_record_buffer();
        int unsigned pool[3];
        int unsigned n_rec;
        int unsigned total;
        int unsigned keep;
        logic [15:0] sz;
        bit          cut_off;
        if ($urandom_range(11) == 0) begin
            // noise
            repeat ($urandom_range(6, 1)) push_byte(8'($urandom));
            end_buffer();
            return;
        end
        foreach (pool[i])
            pool[i] = ($urandom_range(7) == 0) ? $urandom_range(64, 60) : $urandom_range(9, 2);
        n_rec = $urandom_range(10, 1);
        for (int r = 0; r < n_rec; r++) begin
            cut_off = (r == n_rec - 1) && ($urandom_range(4) == 0);
            case ($urandom_range(19))
                0: sz = 16'($urandom_range(1, 0));
                1: sz = 16'($urandom_range(72, 65));
                2: begin
                    // huge size, buffer ends inside it
                    sz      = {8'($urandom_range(255, 1)), 8'($urandom)};
                    cut_off = 1'b1;
                end
                default: sz = 16'(pool[$urandom_range(2)]);
            endcase
            total = (sz < SIZE_BYTES) ? SIZE_BYTES : sz;
            keep  = cut_off ? $urandom_range((total > 12) ? 12 : total - 1, 1) : total;
            emit_record(sz, keep);
            if (cut_off) break;
        end
        end_buffer();
    endfunction

    // row-mode buffer: a few rows, sometimes a partial one at the end
    function automatic void gen_row_buffer(int unsigned rlen);
        int unsigned n;
        if (rlen > 256)
            // long rows: one short partial row keeps the run small
            n = $urandom_range(48, 8);
        else if ($urandom_range(7) == 0)
            n = $urandom_range(rlen, 1);
        else
            n = rlen * $urandom_range(5, 1)
                + (($urandom_range(2) == 0) ? $urandom_range(rlen - 1, 0) : 0);
        repeat (n) push_byte(8'($urandom));
        end_buffer();
    endfunction

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_registers(bit dec, int unsigned rl);
        write_reg(ADDR_DECODE, 32'(dec));
        write_reg(ADDR_ROW_LEN, rl);
        sb.set_config(dec, rl);
    endtask

    // send every queued item in bursts, then wait for all results
    task automatic drive_buffers();
        t_stream_byte item;
        int unsigned  burst;
        int unsigned  gap;
        burst = 0;
        while (buffer_bytes.size() > 0) begin
            if (burst == 0) begin
                gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(24, 1);
            end
            item = buffer_bytes.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= item.data;
            s_axis_tlast  <= item.last;
            do @(posedge i_clk); while (!s_axis_tready);
            sb.note_byte_in(item.data, item.last);
            burst--;
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(bit dec, int unsigned rl, int unsigned target);
        int unsigned eff;
        eff = (rl > MAX_ROW) ? MAX_ROW : rl;
        set_registers(dec, rl);
        while (buffer_bytes.size() < target) begin
            if (eff == 0) gen_record_buffer();
            else          gen_row_buffer(eff);
        end
        drive_buffers();
    endtask

    initial begin
        bit          ph_dec [10];
        int unsigned ph_len [10];
        int unsigned ph_cnt [10];

        ph_dec = '{0, 1, 0, 1, 0, 1, 1, 0, 1, 0};
        ph_len = '{0, 0, 1, 2, 7, 16, 8191, 37, 5, 0};
        ph_cnt = '{170, 170, 60, 60, 100, 100, 1, 100, 60, 130};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // records: repeated size, sizes one and zero, size two twice,
        // then a huge size cut by the end of the buffer
        set_registers(1'b0, 0);
        push_byte(8'h00); push_byte(8'h04); push_byte(8'hAA); push_byte(8'h55);
        push_byte(8'h00); push_byte(8'h04); push_byte(8'hFF); push_byte(8'h00);
        push_byte(8'h00); push_byte(8'h01);
        push_byte(8'h00); push_byte(8'h00);
        push_byte(8'h00); push_byte(8'h02);
        push_byte(8'h00); push_byte(8'h02);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h12);
        end_buffer();
        drive_buffers();

        // rows of three with a partial last row
        set_registers(1'b0, 3);
        push_byte(8'h01); push_byte(8'h02); push_byte(8'h03);
        push_byte(8'hFE); push_byte(8'h00); push_byte(8'h80);
        push_byte(8'h7F);
        end_buffer();
        drive_buffers();

        // random buffers under each register setting
        for (int p = 0; p < 10; p++)
            run_phase(ph_dec[p], ph_len[p], ph_cnt[p]);

        // catch stray output after the last byte
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
